/* rtl/spq_pkg.sv */
package spq_pkg;

    localparam int KEY_W   = 31;
    localparam int PRI_W   = 8;
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;
    localparam int OCC_W   = 5;
    localparam int ENTRY_W = KEY_W + PRI_W;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PRI_W-1:0] pri;
    } entry_t;

endpackage

/* rtl/spq_if.sv */
interface spq_in_if;
    logic                          valid;
    logic                          ready;
    logic [spq_pkg::OP_W-1:0]      opcode;
    logic [spq_pkg::KEY_W-1:0]     item_key;
    logic [spq_pkg::PRI_W-1:0]     item_priority;

    modport source (output valid, output opcode, output item_key, output item_priority,
                    input ready);
    modport sink   (input valid, input opcode, input item_key, input item_priority,
                    output ready);
endinterface

interface spq_out_if;
    logic                          valid;
    logic                          ready;
    logic [spq_pkg::ST_W-1:0]      status;
    logic [spq_pkg::KEY_W-1:0]     out_key;
    logic [spq_pkg::PRI_W-1:0]     out_priority;
    logic [spq_pkg::OCC_W-1:0]     occupancy;

    modport source (output valid, output status, output out_key, output out_priority,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_key, input out_priority,
                    input occupancy, output ready);
endinterface

/* rtl/spq_ram.sv */
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/stable_priority_queue_core.sv */
// steps: insert walks from the tail over the entries behind the new one, then writes
//   it after an entry of equal or higher priority, or at the head; remove and pop
//   walk every entry held; full, empty and idle opcodes answer without a walk
// flow: one word at a time, a new request is taken only in idle; the single ram port pair
//   walks the list one entry at a time (read, then compare and write)
// reset: rst_n clears the entry count and control state; the ram is not cleared
module stable_priority_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    spq_in_if.sink        req,
    spq_out_if.source     rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE = CW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_WNEW,
        S_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [spq_pkg::OP_W-1:0]   op_reg, op_next;
    logic [spq_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [spq_pkg::PRI_W-1:0]  pri_reg, pri_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              res_count_reg, res_count_next;
    logic [spq_pkg::ST_W-1:0]   res_status_reg, res_status_next;
    logic                       found_reg, found_next;
    logic [spq_pkg::KEY_W-1:0]  cap_key_reg, cap_key_next;
    logic [spq_pkg::PRI_W-1:0]  cap_pri_reg, cap_pri_next;
    logic                       out_valid_reg, out_valid_next;
    logic [spq_pkg::ST_W-1:0]   out_status_reg, out_status_next;
    logic [spq_pkg::KEY_W-1:0]  out_key_reg, out_key_next;
    logic [spq_pkg::PRI_W-1:0]  out_pri_reg, out_pri_next;
    logic [spq_pkg::OCC_W-1:0]  out_occ_reg, out_occ_next;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    spq_pkg::entry_t            ram_wdata;
    logic [AW-1:0]              ram_raddr;
    spq_pkg::entry_t            ram_rdata;
    logic [CW-1:0]              idx_dec;
    logic [CW-1:0]              idx_inc;
    logic                       hit;
    logic                       found_now;

    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.out_key      = out_key_reg;
    assign rsp.out_priority = out_pri_reg;
    assign rsp.occupancy    = out_occ_reg;

    assign idx_dec = idx_reg - ONE;
    assign idx_inc = idx_reg + ONE;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        pri_next        = pri_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        found_next      = found_reg;
        cap_key_next    = cap_key_reg;
        cap_pri_next    = cap_pri_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_pri_next    = out_pri_reg;
        out_occ_next    = out_occ_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[AW-1:0];
        ram_wdata       = ram_rdata;
        ram_raddr       = idx_reg[AW-1:0];
        hit             = 1'b0;
        found_now       = found_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = req.opcode;
                    key_next        = req.item_key;
                    pri_next        = req.item_priority;
                    cap_key_next    = '0;
                    cap_pri_next    = '0;
                    found_next      = 1'b0;
                    res_count_next  = count_reg;
                    res_status_next = spq_pkg::ST_OK;
                    state_next      = S_DONE;
                    if (req.opcode == spq_pkg::OP_INSERT)
                    begin
                        if (count_reg == FULL_COUNT)
                        begin
                            res_status_next = spq_pkg::ST_FULL;
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = S_WNEW;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = S_READ;
                        end
                    end
                    else if (req.opcode == spq_pkg::OP_POP ||
                             req.opcode == spq_pkg::OP_REMOVE)
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = (req.opcode == spq_pkg::OP_POP) ?
                                              spq_pkg::ST_EMPTY : spq_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_READ;
                        end
                    end
                end
            end

            S_READ:
            begin
                ram_raddr  = (op_reg == spq_pkg::OP_INSERT) ? idx_dec[AW-1:0]
                                                            : idx_reg[AW-1:0];
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                if (op_reg == spq_pkg::OP_INSERT)
                begin
                    // walking from the tail, shift lower-priority entries up
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg[AW-1:0];
                    if (ram_rdata.pri >= pri_reg)
                    begin
                        ram_wdata.key  = key_reg;
                        ram_wdata.pri  = pri_reg;
                        res_count_next = count_reg + ONE;
                        state_next     = S_DONE;
                    end
                    else if (idx_reg == ONE)
                    begin
                        state_next = S_WNEW;
                    end
                    else
                    begin
                        idx_next   = idx_dec;
                        state_next = S_READ;
                    end
                end
                else
                begin
                    hit = !found_reg &&
                          ((op_reg == spq_pkg::OP_POP) ? (idx_reg == '0)
                                                       : (ram_rdata.key == key_reg));
                    found_now = found_reg || hit;
                    if (found_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = idx_dec[AW-1:0];
                    end
                    if (hit && op_reg == spq_pkg::OP_POP)
                    begin
                        cap_key_next = ram_rdata.key;
                        cap_pri_next = ram_rdata.pri;
                    end
                    found_next = found_now;
                    if (idx_inc == count_reg)
                    begin
                        res_status_next = found_now ? spq_pkg::ST_OK : spq_pkg::ST_NOT_FOUND;
                        res_count_next  = found_now ? idx_reg : count_reg;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_READ;
                    end
                end
            end

            S_WNEW:
            begin
                ram_we         = 1'b1;
                ram_waddr      = '0;
                ram_wdata.key  = key_reg;
                ram_wdata.pri  = pri_reg;
                res_count_next = count_reg + ONE;
                state_next     = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_key_next    = cap_key_reg;
                    out_pri_next    = cap_pri_reg;
                    out_occ_next    = spq_pkg::OCC_W'(res_count_reg);
                    count_next      = res_count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        pri_reg        <= pri_next;
        idx_reg        <= idx_next;
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
        cap_key_reg    <= cap_key_next;
        cap_pri_reg    <= cap_pri_next;
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        out_pri_reg    <= out_pri_next;
        out_occ_reg    <= out_occ_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above depth");

    a_count_only_at_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_DONE) |=> $stable(count_reg))
        else $error("entry count moved outside result stage");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_EVAL || state_reg == S_WNEW))
        else $error("ram write outside write states");

    a_done_loads_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && state_next == S_IDLE) |=> out_valid_reg)
        else $error("result word not presented");

endmodule
